[src/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg: shared definitions for the direct-mapped cache
// Geometry constants, transaction codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;

  // Geometry. Both values must be powers of two and LINES at least 2, since
  // the line store is split into an even bank and an odd bank.
  localparam int LINES      = 64;
  localparam int LINE_BYTES = 16;

  localparam int OFF_W          = $clog2(LINE_BYTES);
  localparam int IDX_W          = $clog2(LINES);
  localparam int TAG_W          = ADDR_W - OFF_W - IDX_W;
  localparam int BANK_W         = IDX_W - 1;
  localparam int BANK_DEPTH     = LINES / 2;
  localparam int ROW_W          = LINE_BYTES * 8;
  localparam int WORDS_PER_LINE = (LINE_BYTES + 3) / 4;
  localparam int CNT_W          = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;

  localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(WORDS_PER_LINE - 1);

  // Input transaction kinds.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;

  // Result transaction kinds.
  localparam logic [KIND_W-1:0] RES_READ_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] RES_FILL_REQ   = 2'd1;
  localparam logic [KIND_W-1:0] RES_WRITE_THRU = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] fill_data;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              hit;
    logic [DATA_W-1:0] hit_total;
    logic [DATA_W-1:0] miss_total;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    logic [ROW_W-1:0]  row;
  } bank_wr_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ROW_W-1:0] row;
  } bank_rd_t;

endpackage

`default_nettype wire

[src/dmc_req_if.sv]
// ----------------------------------------------------------------------------
// dmc_req_if: request channel of the cache
// Carries accesses and fill words with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_req_if;
  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::KIND_W-1:0]  kind;
  logic [dmc_pkg::ADDR_W-1:0]  address;
  logic [dmc_pkg::DATA_W-1:0]  write_data;
  logic [dmc_pkg::DATA_W-1:0]  fill_data;

  modport source (output valid, kind, address, write_data, fill_data, input ready);
  modport sink   (input valid, kind, address, write_data, fill_data, output ready);
endinterface

`default_nettype wire

[src/dmc_rsp_if.sv]
// ----------------------------------------------------------------------------
// dmc_rsp_if: result channel of the cache
// Carries read data, fill requests and write-throughs with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::KIND_W-1:0]  result_kind;
  logic [dmc_pkg::ADDR_W-1:0]  result_address;
  logic [dmc_pkg::DATA_W-1:0]  result_data;
  logic                        was_hit;
  logic [dmc_pkg::DATA_W-1:0]  hit_total;
  logic [dmc_pkg::DATA_W-1:0]  miss_total;

  modport source (output valid, result_kind, result_address, result_data, was_hit,
                  hit_total, miss_total, input ready);
  modport sink   (input valid, result_kind, result_address, result_data, was_hit,
                  hit_total, miss_total, output ready);
endinterface

`default_nettype wire

[src/dmc_bank.sv]
// ----------------------------------------------------------------------------
// dmc_bank: one bank of line storage
// Tag and data rows, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_bank (
  input  wire logic                        clk,
  input  wire dmc_pkg::bank_wr_t           wr,
  input  wire logic                        rd_en,
  input  wire logic [dmc_pkg::BANK_W-1:0]  rd_idx,
  output dmc_pkg::bank_rd_t                rd_data
);

  logic [dmc_pkg::TAG_W-1:0] tag_mem [dmc_pkg::BANK_DEPTH];
  logic [dmc_pkg::ROW_W-1:0] row_mem [dmc_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tag_mem[wr.idx] <= wr.tag;
      row_mem[wr.idx] <= wr.row;
    end
    if (rd_en) begin
      rd_data.tag <= tag_mem[rd_idx];
      rd_data.row <= row_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

[src/dmc_ctrl.sv]
// ----------------------------------------------------------------------------
// dmc_ctrl: lookup and fill control of the cache
// Hit check, byte moves, fill sequencing, counters and result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             s1_valid,
  input  wire logic                             step,
  input  wire dmc_pkg::item_t                   item,
  input  wire dmc_pkg::bank_rd_t [1:0]          bank_rd,
  output logic                                  res_valid,
  output dmc_pkg::result_t                      res,
  output dmc_pkg::bank_wr_t [1:0]               bank_wr,
  output logic [dmc_pkg::ADDR_W-1:0]            pend_addr_nxt
);

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND} phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [dmc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [dmc_pkg::LINES-1:0]    valid_r, valid_nxt;
  logic [dmc_pkg::DATA_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [dmc_pkg::DATA_W-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic                         pend_wr_r, pend_wr_nxt;
  logic [dmc_pkg::ADDR_W-1:0]   pend_addr_r;
  logic [dmc_pkg::DATA_W-1:0]   pend_data_r, pend_data_nxt;
  logic                         pend_hit_r, pend_hit_nxt;
  logic [dmc_pkg::ROW_W-1:0]    buf_r, buf_m;

  logic                         is_acc, is_fill, fill_done, first_ph, second_ph;
  logic                         cur_wr, cur_hit;
  logic [dmc_pkg::ADDR_W-1:0]   cur_addr, addr2, fill_addr;
  logic [dmc_pkg::DATA_W-1:0]   cur_data, rd_word, new_data;
  logic [dmc_pkg::OFF_W-1:0]    off, p;
  logic [dmc_pkg::OFF_W:0]      pos;
  logic [dmc_pkg::IDX_W-1:0]    idx1, idx2, fidx;
  logic [dmc_pkg::TAG_W-1:0]    tag1, tag2;
  logic                         b1, b2, span, hit1, present2;
  logic                         do_first, do_second, req1, req2, fin;
  logic [dmc_pkg::ROW_W-1:0]    row1, row2, row1w, row2w;

  always_comb begin
    is_acc    = s1_valid && (item.kind == dmc_pkg::KIND_READ ||
                             item.kind == dmc_pkg::KIND_WRITE) && phase_r == PH_IDLE;
    is_fill   = s1_valid && item.kind == dmc_pkg::KIND_FILL && phase_r != PH_IDLE;
    fill_done = is_fill && cnt_r == dmc_pkg::LAST_WORD;
    first_ph  = fill_done && phase_r == PH_FIRST;
    second_ph = fill_done && phase_r == PH_SECOND;

    cur_wr   = is_acc ? (item.kind == dmc_pkg::KIND_WRITE) : pend_wr_r;
    cur_addr = is_acc ? item.address : pend_addr_r;
    cur_data = is_acc ? ((item.kind == dmc_pkg::KIND_WRITE) ? item.write_data : '0)
                      : pend_data_r;
    cur_hit  = is_acc ? 1'b1 : pend_hit_r;
    addr2    = cur_addr + dmc_pkg::ADDR_W'(3);

    off  = cur_addr[dmc_pkg::OFF_W-1:0];
    idx1 = cur_addr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
    tag1 = cur_addr[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
    idx2 = addr2[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
    tag2 = addr2[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
    b1   = idx1[0];
    b2   = idx2[0];
    span = off > dmc_pkg::OFF_W'(dmc_pkg::LINE_BYTES - 4);

    // Line buffer with the current fill word dropped into place.
    buf_m = buf_r;
    for (int q = 0; q < dmc_pkg::LINE_BYTES; q++) begin
      if (cnt_r == dmc_pkg::CNT_W'(q / 4)) begin
        buf_m[8*q +: 8] = item.fill_data[31 - 8*(q % 4) -: 8];
      end
    end

    hit1     = valid_r[idx1] && bank_rd[b1].tag == tag1;
    present2 = valid_r[idx2] && bank_rd[b2].tag == tag2;

    do_first  = (is_acc && hit1) || first_ph;
    req1      = is_acc && !hit1;
    req2      = do_first && span && !present2;
    do_second = (do_first && span && present2) || second_ph;
    fin       = (do_first && !span) || do_second;

    row1 = first_ph  ? buf_m : bank_rd[b1].row;
    row2 = second_ph ? buf_m : bank_rd[b2].row;

    // Bytes past the end of the first line wrap to the start of the second.
    rd_word = '0;
    row1w   = row1;
    row2w   = row2;
    for (int i = 0; i < 4; i++) begin
      pos = {1'b0, off} + (dmc_pkg::OFF_W+1)'(i);
      p   = pos[dmc_pkg::OFF_W-1:0];
      if (pos[dmc_pkg::OFF_W]) begin
        if (do_second) rd_word[31 - 8*i -: 8] = row2[8*p +: 8];
        if (cur_wr)    row2w[8*p +: 8] = cur_data[31 - 8*i -: 8];
      end else begin
        if (do_first)  rd_word[31 - 8*i -: 8] = row1[8*p +: 8];
        if (cur_wr)    row1w[8*p +: 8] = cur_data[31 - 8*i -: 8];
      end
    end
    new_data = cur_wr ? cur_data : (cur_data | rd_word);

    fill_addr = (phase_r == PH_FIRST) ? cur_addr : addr2;
    fidx      = fill_addr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];

    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (fin) begin
      if (cur_hit) hit_cnt_nxt  = hit_cnt_r + dmc_pkg::DATA_W'(1);
      else         miss_cnt_nxt = miss_cnt_r + dmc_pkg::DATA_W'(1);
    end

    res_valid      = req1 || req2 || fin;
    res.hit_total  = hit_cnt_nxt;
    res.miss_total = miss_cnt_nxt;
    if (req1 || req2) begin
      res.kind    = dmc_pkg::RES_FILL_REQ;
      res.address = req1 ? {cur_addr[dmc_pkg::ADDR_W-1:dmc_pkg::OFF_W], dmc_pkg::OFF_W'(0)}
                         : {addr2[dmc_pkg::ADDR_W-1:dmc_pkg::OFF_W], dmc_pkg::OFF_W'(0)};
      res.data    = '0;
      res.hit     = 1'b0;
    end else begin
      res.kind    = cur_wr ? dmc_pkg::RES_WRITE_THRU : dmc_pkg::RES_READ_DATA;
      res.address = cur_addr;
      res.data    = new_data;
      res.hit     = cur_hit;
    end

    bank_wr = '0;
    if (step && do_first && (cur_wr || first_ph)) begin
      bank_wr[b1].en  = 1'b1;
      bank_wr[b1].idx = idx1[dmc_pkg::IDX_W-1:1];
      bank_wr[b1].tag = tag1;
      bank_wr[b1].row = row1w;
    end
    if (step && do_second && (cur_wr || second_ph)) begin
      bank_wr[b2].en  = 1'b1;
      bank_wr[b2].idx = idx2[dmc_pkg::IDX_W-1:1];
      bank_wr[b2].tag = tag2;
      bank_wr[b2].row = row2w;
    end

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (req1) begin
      phase_nxt = PH_FIRST;
      cnt_nxt   = '0;
    end else if (req2) begin
      phase_nxt = PH_SECOND;
      cnt_nxt   = '0;
    end else if (fin) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
    end else if (is_fill) begin
      cnt_nxt = cnt_r + dmc_pkg::CNT_W'(1);
    end

    valid_nxt = valid_r;
    if (fill_done) valid_nxt[fidx] = 1'b1;

    pend_wr_nxt   = (step && is_acc) ? cur_wr : pend_wr_r;
    pend_addr_nxt = (step && is_acc) ? item.address : pend_addr_r;
    pend_data_nxt = (is_acc || fill_done) ? new_data : pend_data_r;
    pend_hit_nxt  = (is_acc || fill_done) ? (cur_hit && !req1 && !req2) : pend_hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      valid_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      valid_r    <= valid_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend_wr_r   <= pend_wr_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_data_r <= pend_data_nxt;
      pend_hit_r  <= pend_hit_nxt;
      if (is_fill) buf_r <= buf_m;
    end
  end

endmodule

`default_nettype wire

[src/direct_mapped_write_through_cache.sv]
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache: L1 cache, direct mapped, write through
// Top level: input stage, banked line store, lookup control, result register.
// ----------------------------------------------------------------------------
// Usage. The in_req channel takes three kinds of transaction: a 4-byte read,
// a 4-byte write, and a fill word returned by the next level. The out_rsp
// channel gives read data, fill requests (line-aligned address) and
// write-throughs, each stamped with the running hit and miss totals.
// Both channels use valid/ready; a transaction moves when both are high.
//
// Throughput is one transaction per cycle while out_rsp does not stall. A
// transaction is registered at its accepting edge while the line store is
// read at the same edge; when the stage advances, its result is loaded into
// the output register behind out_rsp.valid. The line store is two banks
// (even and odd lines) so an access straddling a line boundary sees both of
// its lines in one pass. A miss raises a fill request; until the last fill
// word of that line arrives, accesses are taken and dropped without result.
// Fill words that arrive with no fill outstanding are dropped as well.
//
// Reset clears all line valid bits, the fill sequencer and both totals at
// once; there is no clearing pass. If out_rsp stalls while a result waits,
// the block still takes one more transaction and holds it; it then drops
// in_req.ready only if that transaction would produce a result too.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_write_through_cache (
  input wire logic   clk,
  input wire logic   rst_n,
  dmc_req_if.sink    in_req,
  dmc_rsp_if.source  out_rsp
);

  // Input stage.
  logic                 s1_valid_r;
  dmc_pkg::item_t       s1_r;

  // Result register.
  logic                 out_valid_r;
  dmc_pkg::result_t     out_r;

  logic                 res_valid;
  dmc_pkg::result_t     res;
  logic                 s1_adv, step, in_ready, in_acc;

  dmc_pkg::bank_wr_t [1:0]        bank_wr;
  dmc_pkg::bank_wr_t [1:0]        fwd_r;
  dmc_pkg::bank_rd_t [1:0]        bank_raw, bank_rd;
  logic [dmc_pkg::BANK_W-1:0]     rd_idx [2];
  logic [dmc_pkg::BANK_W-1:0]     rd_idx_r [2];

  logic [dmc_pkg::ADDR_W-1:0]     pend_addr_nxt, rd_addr, rd_addr2;
  logic [dmc_pkg::IDX_W-1:0]      ri1, ri2;

  // The stage advances unless its transaction has a result and the result
  // register is full and stalled.
  assign s1_adv   = !res_valid || !out_valid_r || out_rsp.ready;
  assign step     = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_req.valid && in_ready;
  assign in_req.ready = in_ready;

  // Line store read address. A fill word works on the pending access, whose
  // address may be set by the transaction in the stage at this very edge.
  assign rd_addr  = (in_req.kind == dmc_pkg::KIND_FILL) ? pend_addr_nxt : in_req.address;
  assign rd_addr2 = rd_addr + dmc_pkg::ADDR_W'(3);
  assign ri1      = rd_addr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
  assign ri2      = rd_addr2[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];

  // Each bank serves the first line if it lives there, else the second.
  assign rd_idx[0] = ri1[0] ? ri2[dmc_pkg::IDX_W-1:1] : ri1[dmc_pkg::IDX_W-1:1];
  assign rd_idx[1] = ri1[0] ? ri1[dmc_pkg::IDX_W-1:1] : ri2[dmc_pkg::IDX_W-1:1];

  dmc_bank u_bank0 (
    .clk     (clk),
    .wr      (bank_wr[0]),
    .rd_en   (in_acc),
    .rd_idx  (rd_idx[0]),
    .rd_data (bank_raw[0])
  );

  dmc_bank u_bank1 (
    .clk     (clk),
    .wr      (bank_wr[1]),
    .rd_en   (in_acc),
    .rd_idx  (rd_idx[1]),
    .rd_data (bank_raw[1])
  );

  // A write made at the same edge as the read is not seen by the read, so
  // the write is kept and forwarded when the indexes match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
    end else if (in_acc) begin
      fwd_r       <= bank_wr;
      rd_idx_r[0] <= rd_idx[0];
      rd_idx_r[1] <= rd_idx[1];
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (fwd_r[b].en && fwd_r[b].idx == rd_idx_r[b]) begin
        bank_rd[b].tag = fwd_r[b].tag;
        bank_rd[b].row = fwd_r[b].row;
      end else begin
        bank_rd[b] = bank_raw[b];
      end
    end
  end

  dmc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid_r),
    .step          (step),
    .item          (s1_r),
    .bank_rd       (bank_rd),
    .res_valid     (res_valid),
    .res           (res),
    .bank_wr       (bank_wr),
    .pend_addr_nxt (pend_addr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)    s1_valid_r <= 1'b1;
      else if (step) s1_valid_r <= 1'b0;

      if (step && res_valid)  out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.kind       <= in_req.kind;
      s1_r.address    <= in_req.address;
      s1_r.write_data <= in_req.write_data;
      s1_r.fill_data  <= in_req.fill_data;
    end
    if (step && res_valid) out_r <= res;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.result_kind    = out_r.kind;
  assign out_rsp.result_address = out_r.address;
  assign out_rsp.result_data    = out_r.data;
  assign out_rsp.was_hit        = out_r.hit;
  assign out_rsp.hit_total      = out_r.hit_total;
  assign out_rsp.miss_total     = out_r.miss_total;

  // The input side stalls only behind a held result that cannot move.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_rsp.ready && res_valid)
    else $error("input stalled without a blocked result");

  // A result leaving the stage is in the result register on the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid |=> out_valid_r)
    else $error("result lost between stage and output register");

  // Fill requests are line aligned and never flagged as hits.
  a_fill_req_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == dmc_pkg::RES_FILL_REQ
      |-> !out_r.hit && out_r.address[dmc_pkg::OFF_W-1:0] == '0 && out_r.data == '0)
    else $error("malformed fill request");

  // The two banks are written at the same edge only while the stage advances.
  a_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    bank_wr[0].en && bank_wr[1].en |-> step)
    else $error("line store written without the stage advancing");

endmodule

`default_nettype wire
